// ===== sv/snfs_pkg.sv =====
`default_nettype none
package snfs_pkg;
    localparam int unsigned CAPACITY_BYTES_DEF = 16777216;
    localparam int unsigned PAGE_BYTES_DEF     = 256;
    localparam int unsigned SECTOR_BYTES_DEF   = 4096;

    localparam logic [7:0] OP_WREN  = 8'h06;
    localparam logic [7:0] OP_RDSR  = 8'h05;
    localparam logic [7:0] OP_WRSR  = 8'h01;
    localparam logic [7:0] OP_RDID  = 8'h9F;
    localparam logic [7:0] OP_QREAD = 8'h6B;
    localparam logic [7:0] OP_PP    = 8'h02;
    localparam logic [7:0] OP_SE    = 8'h20;
    localparam logic [7:0] ST_QE    = 8'h40;
    localparam logic [23:0] DEV_ID  = {8'hC2, 8'h20, 8'h18};
    localparam logic [3:0] QREAD_DUMMY = 4'd8;

    typedef enum logic [3:0] {
        CMD_READ = 4'd0, CMD_PROG = 4'd1, CMD_ERASE = 4'd2, CMD_INIT = 4'd3,
        CMD_STAT = 4'd4, CMD_ID = 4'd5, CMD_DONE = 4'd6, CMD_ERR = 4'd7,
        CMD_TICK = 4'd8
    } t_cmd;

    typedef enum logic [2:0] {
        STS_OK = 3'd0, STS_PARAM = 3'd1, STS_NOT_READY = 3'd2,
        STS_TIMEOUT = 3'd3, STS_IO = 3'd4, STS_WRONG_DEV = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0, DIR_READ = 2'd1, DIR_WRITE = 2'd2
    } t_dir;

    typedef enum logic [1:0] {
        OPN_READ = 2'd0, OPN_PROG = 2'd1, OPN_ERASE = 2'd2, OPN_INIT = 2'd3
    } t_opn;

    typedef enum logic [3:0] {
        PH_IDLE, PH_POWERUP, PH_ID, PH_QE_STAT, PH_WEN_DONE, PH_WEL_STAT,
        PH_WRSR_DONE, PH_PRE_STAT, PH_PRE_TICK, PH_POST_STAT, PH_POST_TICK,
        PH_QE_CHECK, PH_READ_DONE, PH_PROG_DONE, PH_ERASE_DONE
    } t_phase;

    // classified event passed from the front to the back
    // pre_bad: parameter error ahead of the ready check; post_bad: after it
    typedef struct packed {
        logic        is_req;
        logic        pre_bad;
        logic        post_bad;
        t_cmd        cmd;
        logic [23:0] address;
        logic [24:0] length;
        logic [15:0] req_limit;
        logic [7:0]  status_byte;
        logic        id_match;
    } t_evt;

    typedef struct packed {
        logic        kind;
        logic [7:0]  opcode;
        logic [23:0] flash_address;
        logic [1:0]  address_bytes;
        logic [3:0]  dummy_cycles;
        logic        quad_data;
        t_dir        direction;
        logic [24:0] byte_count;
        logic [23:0] data_offset;
        logic [7:0]  write_byte;
        t_status     status;
    } t_res;
endpackage
`default_nettype wire

// ===== sv/snfs_front.sv =====
`default_nettype none
module snfs_front #(
    parameter int unsigned CAPACITY_BYTES = snfs_pkg::CAPACITY_BYTES_DEF,
    parameter int unsigned SECTOR_BYTES   = snfs_pkg::SECTOR_BYTES_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire logic [3:0]   i_command,
    input  wire logic [23:0]  i_address,
    input  wire logic [24:0]  i_length,
    input  wire logic [15:0]  i_req_limit,
    input  wire logic [7:0]   i_status_byte,
    input  wire logic [23:0]  i_id_value,
    output logic              o_valid,
    input  wire logic         i_stall,
    output snfs_pkg::t_evt    o_evt
);
    import snfs_pkg::*;

    localparam logic [25:0] CAP = 26'(CAPACITY_BYTES);
    localparam int unsigned SB = $clog2(SECTOR_BYTES);

    t_evt  n_evt;
    t_evt  r_evt;
    logic  r_valid;
    logic  bad_rng;
    logic  bad_align;
    logic  addr_over;

    // the ready check needs the back's current state, so it is left to the back
    always_comb begin
        addr_over = {2'b00, i_address} >= CAP;
        bad_rng   = (i_length == '0) || addr_over ||
                    ({1'b0, i_length} > (CAP - {2'b00, i_address}));
        bad_align = (i_address[SB-1:0] != '0) || addr_over;
        n_evt = '0;
        n_evt.cmd         = t_cmd'(i_command);
        n_evt.address     = i_address;
        n_evt.length      = i_length;
        n_evt.req_limit   = i_req_limit;
        n_evt.status_byte = i_status_byte;
        n_evt.id_match    = i_id_value == DEV_ID;
        unique case (i_command)
            CMD_READ, CMD_PROG: begin
                n_evt.is_req   = 1'b1;
                n_evt.pre_bad  = i_req_limit == '0;
                n_evt.post_bad = bad_rng;
            end
            CMD_ERASE: begin
                n_evt.is_req  = 1'b1;
                n_evt.pre_bad = (i_req_limit == '0) || bad_align;
            end
            CMD_INIT: begin
                n_evt.is_req  = 1'b1;
                n_evt.pre_bad = i_req_limit == '0;
            end
            default: n_evt.is_req = 1'b0;
        endcase
    end

    assign o_stall = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_evt   = r_evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_evt <= n_evt;
        end
    end
endmodule
`default_nettype wire

// ===== sv/snfs_back.sv =====
`default_nettype none
module snfs_back #(
    parameter int unsigned PAGE_BYTES = snfs_pkg::PAGE_BYTES_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  snfs_pkg::t_evt    i_evt,
    output logic              o_valid,
    input  wire logic         i_stall,
    output snfs_pkg::t_res    o_res
);
    import snfs_pkg::*;

    localparam int unsigned PB = $clog2(PAGE_BYTES);

    t_phase      r_phase, n_phase;
    t_opn        r_op, n_op;
    logic        r_init, n_init;
    logic [23:0] r_addr, n_addr;
    logic [24:0] r_left, n_left;
    logic [23:0] r_off, n_off;
    logic [15:0] r_ticks, n_ticks;
    logic [15:0] r_limit, n_limit;
    logic [7:0]  r_saved, n_saved;
    logic        r_ovalid;
    t_res        r_res, n_res;
    logic        emit;
    logic        take;
    logic [24:0] room;
    logic [24:0] chunk;
    logic        tmo_hit;
    t_evt        e;

    // output register holds one result; accept whenever it is free or drains now
    assign o_stall = r_ovalid && i_stall;
    assign take    = i_valid && !o_stall;
    assign e       = i_evt;
    assign o_valid = r_ovalid;
    assign o_res   = r_res;

    always_comb begin
        room  = 25'(PAGE_BYTES) - {{(25-PB){1'b0}}, r_addr[PB-1:0]};
        chunk = (r_left < room) ? r_left : room;
    end

    always_comb begin
        n_phase = r_phase; n_op = r_op; n_init = r_init; n_addr = r_addr;
        n_left = r_left; n_off = r_off; n_ticks = r_ticks; n_limit = r_limit;
        n_saved = r_saved;
        n_res = '0;
        emit = 1'b0;
        tmo_hit = 1'b0;
        if (take) begin
            if (r_phase == PH_IDLE) begin
                if (e.is_req) begin
                    if (e.pre_bad) begin
                        emit = 1'b1; n_res.kind = 1'b1; n_res.status = STS_PARAM;
                    end else if (e.cmd != CMD_INIT && !r_init) begin
                        emit = 1'b1; n_res.kind = 1'b1; n_res.status = STS_NOT_READY;
                    end else if (e.post_bad) begin
                        emit = 1'b1; n_res.kind = 1'b1; n_res.status = STS_PARAM;
                    end else begin
                        n_op = t_opn'(e.cmd[1:0]);
                        n_off = '0; n_ticks = '0; n_limit = e.req_limit;
                        if (e.cmd == CMD_INIT) begin
                            n_init = 1'b0; n_addr = '0; n_left = '0;
                            n_phase = PH_POWERUP;
                        end else begin
                            n_addr = e.address;
                            n_left = (e.cmd == CMD_ERASE) ? '0 : e.length;
                            emit = 1'b1; n_phase = PH_PRE_STAT;
                            n_res.opcode = OP_RDSR; n_res.direction = DIR_READ;
                            n_res.byte_count = 25'd1;
                        end
                    end
                end
            end else if (e.cmd == CMD_TICK) begin
                if (r_phase == PH_POWERUP) begin
                    emit = 1'b1; n_phase = PH_ID; n_res.opcode = OP_RDID;
                    n_res.direction = DIR_READ; n_res.byte_count = 25'd3;
                end else begin
                    if (r_ticks != 16'hFFFF) n_ticks = r_ticks + 16'd1;
                    if (r_phase == PH_PRE_TICK || r_phase == PH_POST_TICK) begin
                        emit = 1'b1;
                        n_phase = (r_phase == PH_PRE_TICK) ? PH_PRE_STAT : PH_POST_STAT;
                        n_res.opcode = OP_RDSR; n_res.direction = DIR_READ;
                        n_res.byte_count = 25'd1;
                    end
                end
            end else if (e.cmd == CMD_ERR) begin
                if (!(r_phase == PH_POWERUP || r_phase == PH_PRE_TICK ||
                      r_phase == PH_POST_TICK)) begin
                    emit = 1'b1; n_res.kind = 1'b1; n_res.status = STS_IO;
                end
            end else begin
                priority case (r_phase)
                    PH_ID: if (e.cmd == CMD_ID) begin
                        emit = 1'b1;
                        if (!e.id_match) begin
                            n_res.kind = 1'b1; n_res.status = STS_WRONG_DEV;
                        end else begin
                            n_phase = PH_QE_STAT; n_res.opcode = OP_RDSR;
                            n_res.direction = DIR_READ; n_res.byte_count = 25'd1;
                        end
                    end
                    PH_QE_STAT: if (e.cmd == CMD_STAT) begin
                        emit = 1'b1; n_saved = e.status_byte;
                        if (e.status_byte[6]) begin
                            n_init = 1'b1; n_res.kind = 1'b1;
                        end else begin
                            n_phase = PH_WEN_DONE; n_res.opcode = OP_WREN;
                        end
                    end
                    PH_WEN_DONE: if (e.cmd == CMD_DONE) begin
                        emit = 1'b1; n_phase = PH_WEL_STAT; n_res.opcode = OP_RDSR;
                        n_res.direction = DIR_READ; n_res.byte_count = 25'd1;
                    end
                    PH_WEL_STAT: if (e.cmd == CMD_STAT) begin
                        emit = 1'b1;
                        if (!e.status_byte[1]) begin
                            n_res.kind = 1'b1; n_res.status = STS_IO;
                        end else begin
                            unique case (r_op)
                                OPN_INIT: begin
                                    n_phase = PH_WRSR_DONE; n_res.opcode = OP_WRSR;
                                    n_res.direction = DIR_WRITE;
                                    n_res.byte_count = 25'd1;
                                    n_res.write_byte = r_saved | ST_QE;
                                end
                                OPN_PROG: begin
                                    n_phase = PH_PROG_DONE; n_res.opcode = OP_PP;
                                    n_res.flash_address = r_addr;
                                    n_res.address_bytes = 2'd3;
                                    n_res.direction = DIR_WRITE;
                                    n_res.byte_count = chunk;
                                    n_res.data_offset = r_off;
                                end
                                OPN_ERASE: begin
                                    n_phase = PH_ERASE_DONE; n_res.opcode = OP_SE;
                                    n_res.flash_address = r_addr;
                                    n_res.address_bytes = 2'd3;
                                end
                                default: n_res.kind = 1'b1;
                            endcase
                        end
                    end
                    PH_WRSR_DONE, PH_ERASE_DONE, PH_PROG_DONE: if (e.cmd == CMD_DONE) begin
                        if (r_phase == PH_PROG_DONE) begin
                            n_addr = r_addr + chunk[23:0];
                            n_off = r_off + chunk[23:0];
                            n_left = r_left - chunk;
                        end
                        emit = 1'b1; n_phase = PH_POST_STAT; n_res.opcode = OP_RDSR;
                        n_res.direction = DIR_READ; n_res.byte_count = 25'd1;
                    end
                    PH_PRE_STAT: if (e.cmd == CMD_STAT) begin
                        if (e.status_byte[0]) begin
                            n_phase = PH_PRE_TICK;
                        end else begin
                            emit = 1'b1;
                            unique case (r_op)
                                OPN_READ: begin
                                    n_phase = PH_READ_DONE; n_res.opcode = OP_QREAD;
                                    n_res.flash_address = r_addr;
                                    n_res.address_bytes = 2'd3;
                                    n_res.dummy_cycles = QREAD_DUMMY;
                                    n_res.quad_data = 1'b1;
                                    n_res.direction = DIR_READ;
                                    n_res.byte_count = r_left;
                                end
                                OPN_PROG, OPN_ERASE: begin
                                    n_phase = PH_WEN_DONE; n_res.opcode = OP_WREN;
                                end
                                default: n_res.kind = 1'b1;
                            endcase
                        end
                    end
                    PH_POST_STAT: if (e.cmd == CMD_STAT) begin
                        if (e.status_byte[0]) begin
                            n_phase = PH_POST_TICK;
                        end else begin
                            emit = 1'b1;
                            if (r_op == OPN_INIT) begin
                                n_phase = PH_QE_CHECK; n_res.opcode = OP_RDSR;
                                n_res.direction = DIR_READ; n_res.byte_count = 25'd1;
                            end else if (r_op == OPN_PROG && r_left != '0) begin
                                n_phase = PH_WEN_DONE; n_res.opcode = OP_WREN;
                            end else begin
                                n_res.kind = 1'b1;
                            end
                        end
                    end
                    PH_QE_CHECK: if (e.cmd == CMD_STAT) begin
                        emit = 1'b1; n_res.kind = 1'b1;
                        if (!e.status_byte[6]) n_res.status = STS_IO;
                        else n_init = 1'b1;
                    end
                    PH_READ_DONE: if (e.cmd == CMD_DONE) begin
                        emit = 1'b1; n_res.kind = 1'b1;
                    end
                    default: ;
                endcase
            end
            // every descriptor is checked against the time limit before it is issued
            if (emit && !n_res.kind && r_phase != PH_IDLE && n_ticks >= n_limit) begin
                tmo_hit = 1'b1;
                n_res = '0; n_res.kind = 1'b1; n_res.status = STS_TIMEOUT;
                n_init = r_init; n_saved = n_saved;
            end
            if (emit && !n_res.kind && r_phase == PH_IDLE && n_limit == '0) begin
                tmo_hit = 1'b1;
                n_res = '0; n_res.kind = 1'b1; n_res.status = STS_TIMEOUT;
            end
            if (emit && n_res.kind) n_phase = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_op <= OPN_READ; r_init <= 1'b0;
            r_addr <= '0; r_left <= '0; r_off <= '0; r_ticks <= '0;
            r_limit <= '0; r_saved <= '0; r_ovalid <= 1'b0;
        end else begin
            r_phase <= n_phase; r_op <= n_op; r_init <= n_init;
            r_addr <= n_addr; r_left <= n_left; r_off <= n_off;
            r_ticks <= n_ticks; r_limit <= n_limit; r_saved <= n_saved;
            if (!o_stall) r_ovalid <= emit;
        end
        if (!o_stall && emit) r_res <= n_res;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && i_stall |=> r_ovalid && $stable(r_res))
        else $error("result dropped under stall");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && tmo_hit |=> r_phase == PH_IDLE)
        else $error("timeout did not end request");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_res.kind |-> r_phase == PH_IDLE || $past(r_phase) == PH_IDLE)
        else $error("completion without idle");
endmodule
`default_nettype wire

// ===== sv/serial_nor_flash_sequencer.sv =====
// Structure: each event passes through a classification register and then a
// result register before its result appears.
// Throughput: one event per cycle; the result register stalls the back end
// and the front register only when a result waits.
// Reset: synchronous active low; returns to idle, device not initialized.
`default_nettype none
module serial_nor_flash_sequencer #(
    parameter int unsigned CAPACITY_BYTES = snfs_pkg::CAPACITY_BYTES_DEF,
    parameter int unsigned PAGE_BYTES     = snfs_pkg::PAGE_BYTES_DEF,
    parameter int unsigned SECTOR_BYTES   = snfs_pkg::SECTOR_BYTES_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire logic [3:0]   i_command,
    input  wire logic [23:0]  i_address,
    input  wire logic [24:0]  i_length,
    input  wire logic [15:0]  i_req_limit,
    input  wire logic [7:0]   i_status_byte,
    input  wire logic [23:0]  i_id_value,
    output logic              o_valid,
    input  wire logic         i_stall,
    output logic              o_kind,
    output logic [7:0]        o_opcode,
    output logic [23:0]       o_flash_address,
    output logic [1:0]        o_address_bytes,
    output logic [3:0]        o_dummy_cycles,
    output logic              o_quad_data,
    output logic [1:0]        o_direction,
    output logic [24:0]       o_byte_count,
    output logic [23:0]       o_data_offset,
    output logic [7:0]        o_write_byte,
    output logic [2:0]        o_status
);
    import snfs_pkg::*;

    t_evt evt;
    t_res res;
    logic evt_valid;
    logic evt_stall;

    snfs_front #(.CAPACITY_BYTES(CAPACITY_BYTES), .SECTOR_BYTES(SECTOR_BYTES)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_command, .i_address, .i_length, .i_req_limit, .i_status_byte, .i_id_value,
        .o_valid(evt_valid), .i_stall(evt_stall), .o_evt(evt)
    );

    snfs_back #(.PAGE_BYTES(PAGE_BYTES)) u_back (
        .i_clk, .i_rst_n, .i_valid(evt_valid), .o_stall(evt_stall), .i_evt(evt),
        .o_valid, .i_stall, .o_res(res)
    );

    assign o_kind          = res.kind;
    assign o_opcode        = res.opcode;
    assign o_flash_address = res.flash_address;
    assign o_address_bytes = res.address_bytes;
    assign o_dummy_cycles  = res.dummy_cycles;
    assign o_quad_data     = res.quad_data;
    assign o_direction     = res.direction;
    assign o_byte_count    = res.byte_count;
    assign o_data_offset   = res.data_offset;
    assign o_write_byte    = res.write_byte;
    assign o_status        = res.status;
endmodule
`default_nettype wire
